// ===== hdl/vpr_pkg.sv =====
// Package for the vector polar/rect unit: payload structs, command codes,
// fixed-point constants, arctangent table and shared gain/saturation functions.
// No dependencies.
package vpr_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int GUARD_BITS      = 8;
  localparam int ANG_BITS        = 24;
  localparam int ANG_SHIFT       = ANG_BITS - FRAC_BITS;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int FRONT_STAGES    = 2;

  // vector width with guard bits and CORDIC growth, angle width in Q.24
  localparam int XW  = 44;
  localparam int ZW  = 36;
  localparam int W_W = 34;
  localparam int Q_W = 16;
  localparam int R_W = 34;

  localparam logic [29:0] GAIN_Q30    = 30'd652032874;
  localparam longint      RAD_DEG_Q24 = 64'sd961263669;

  // angle range reduction, degrees in Q.FRAC
  localparam longint MOD_Q16     = longint'(360) << FRAC_BITS;
  localparam longint HALF_Q16    = longint'(180) << FRAC_BITS;
  localparam longint QUARTER_Q16 = longint'(90) << FRAC_BITS;
  localparam longint HALF_Q24    = longint'(180) << ANG_BITS;
  localparam longint BIAS        = ((longint'(1) << 31) / MOD_Q16 + 1) * MOD_Q16;
  localparam longint RECIP       = (longint'(1) << 40) / MOD_Q16;

  localparam logic signed [XW-1:0] GUARD_RND = XW'(1) << (GUARD_BITS - 1);
  localparam logic signed [ZW-1:0] ANG_RND   =
    (ANG_SHIFT == 0) ? ZW'(0) : ZW'(longint'(1) << (ANG_SHIFT - 1));
  localparam logic signed [63:0]   FRAC_RND  = 64'(longint'(1) << (FRAC_BITS - 1));

  localparam logic [2:0] CMD_P2R   = 3'd0;
  localparam logic [2:0] CMD_R2P   = 3'd1;
  localparam logic [2:0] CMD_ADD   = 3'd2;
  localparam logic [2:0] CMD_SUB   = 3'd3;
  localparam logic [2:0] CMD_NEG   = 3'd4;
  localparam logic [2:0] CMD_SCALE = 3'd5;

  typedef enum logic [1:0] {
    OP_ROT,
    OP_VEC,
    OP_PASS
  } op_e;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] a_first;
    logic signed [31:0] a_second;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] factor;
  } req_t;

  typedef struct packed {
    logic signed [31:0] out_first;
    logic signed [31:0] out_second;
    logic               bad_command;
    logic               saturated;
  } rsp_t;

  typedef struct packed {
    op_e                  op;
    logic                 neg;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    rsp_t                 res;
  } entry_t;

  typedef struct packed {
    logic        neg;
    logic [58:0] p_hi;
    logic [44:0] p_lo;
  } gain_prod_t;

  // arctangent of 2^-i in degrees Q.24
  function automatic logic [31:0] atan_q24(input int unsigned i);
    logic [31:0] r;
    case (i)
      0:  r = 32'd754974720;
      1:  r = 32'd445687602;
      2:  r = 32'd235489088;
      3:  r = 32'd119537938;
      4:  r = 32'd60000934;
      5:  r = 32'd30029717;
      6:  r = 32'd15018523;
      7:  r = 32'd7509720;
      8:  r = 32'd3754917;
      9:  r = 32'd1877466;
      10: r = 32'd938734;
      11: r = 32'd469367;
      default: r = 32'((RAD_DEG_Q24 + (longint'(1) << (i - 1))) >> i);
    endcase
    return r;
  endfunction

  // first half of round(v * gain): split magnitude, two partial products
  function automatic gain_prod_t gain_prep(input logic signed [XW-1:0] v);
    gain_prod_t       p;
    logic [XW-1:0]    m;
    m = v[XW-1] ? XW'(-v) : XW'(v);
    p.neg  = v[XW-1];
    p.p_hi = 59'(m[XW-1:15]) * 59'(GAIN_Q30);
    p.p_lo = 45'(m[14:0]) * 45'(GAIN_Q30);
    return p;
  endfunction

  // second half: combine partial products, round, restore sign
  function automatic logic signed [XW-1:0] gain_done(input gain_prod_t p);
    logic [59:0]          t;
    logic signed [XW-1:0] mag;
    t   = 60'(p.p_hi) + 60'(p.p_lo >> 15);
    t   = (t + 60'h4000) >> 15;
    mag = XW'(t);
    return p.neg ? -mag : mag;
  endfunction

  // clip to 32 bits, MSB of result is the clip flag
  function automatic logic [32:0] sat32(input logic signed [63:0] v);
    logic [32:0] r;
    if (v > 64'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -64'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

// ===== hdl/vpr_front.sv =====
// Front end: accepts commands, does vector arithmetic, angle reduction and
// CORDIC setup, and pushes one entry per item into the queue. Uses vpr_pkg.
module vpr_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  vpr_pkg::req_t   req_i,
  output logic            push_o,
  output vpr_pkg::entry_t entry_o
);

  localparam int XW  = vpr_pkg::XW;
  localparam int ZW  = vpr_pkg::ZW;
  localparam int R_W = vpr_pkg::R_W;

  // stage 1
  logic                    v1_q;
  logic [2:0]              cmd1_q;
  logic signed [31:0]      a1_1_q, a2_1_q;
  vpr_pkg::gain_prod_t     gp1_q;
  logic [vpr_pkg::W_W-1:0] w1_q, w1_d;
  logic [vpr_pkg::Q_W-1:0] q1_q;
  logic signed [33:0]      sum1_q, sum2_q, sum1_d, sum2_d;
  logic signed [63:0]      mp1_q, mp2_q;
  logic signed [XW-1:0]    ax1_d;

  // stage 2
  logic                    v2_q;
  logic [2:0]              cmd2_q;
  logic signed [31:0]      a1_2_q, a2_2_q;
  logic [R_W-1:0]          r2_q, r2_d;
  logic signed [XW-1:0]    x2_q;
  vpr_pkg::rsp_t           res2_q, res2_d;

  always_comb begin
    ax1_d = XW'(req_i.a_first) <<< vpr_pkg::GUARD_BITS;
    w1_d  = vpr_pkg::W_W'(64'(req_i.a_second) + vpr_pkg::BIAS);
    case (req_i.cmd)
      vpr_pkg::CMD_ADD: begin
        sum1_d = 34'(req_i.a_first) + 34'(req_i.b_x);
        sum2_d = 34'(req_i.a_second) + 34'(req_i.b_y);
      end
      vpr_pkg::CMD_SUB: begin
        sum1_d = 34'(req_i.a_first) - 34'(req_i.b_x);
        sum2_d = 34'(req_i.a_second) - 34'(req_i.b_y);
      end
      vpr_pkg::CMD_NEG: begin
        sum1_d = -34'(req_i.a_first);
        sum2_d = -34'(req_i.a_second);
      end
      default: begin
        sum1_d = '0;
        sum2_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= accept_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd1_q <= req_i.cmd;
    a1_1_q <= req_i.a_first;
    a2_1_q <= req_i.a_second;
    gp1_q  <= vpr_pkg::gain_prep(ax1_d);
    w1_q   <= w1_d;
    q1_q   <= vpr_pkg::Q_W'((64'(w1_d) * 64'(vpr_pkg::RECIP)) >> 40);
    sum1_q <= sum1_d;
    sum2_q <= sum2_d;
    mp1_q  <= 64'(req_i.a_first) * 64'(req_i.factor);
    mp2_q  <= 64'(req_i.a_second) * 64'(req_i.factor);
  end

  // stage 2: finish reduction modulo one turn, gain, rounding, clipping
  always_comb begin
    logic [39:0]        rr;
    logic [32:0]        s1, s2;
    logic signed [63:0] sc1, sc2;
    rr = 40'(w1_q) - 40'(q1_q) * 40'(vpr_pkg::MOD_Q16);
    if (rr >= 40'(vpr_pkg::MOD_Q16)) begin
      rr = rr - 40'(vpr_pkg::MOD_Q16);
    end
    r2_d = R_W'(rr);
    sc1 = (mp1_q + vpr_pkg::FRAC_RND) >>> vpr_pkg::FRAC_BITS;
    sc2 = (mp2_q + vpr_pkg::FRAC_RND) >>> vpr_pkg::FRAC_BITS;
    res2_d = '0;
    s1 = '0;
    s2 = '0;
    case (cmd1_q)
      vpr_pkg::CMD_P2R, vpr_pkg::CMD_R2P: begin
        res2_d = '0;
      end
      vpr_pkg::CMD_ADD, vpr_pkg::CMD_SUB, vpr_pkg::CMD_NEG: begin
        s1 = vpr_pkg::sat32(64'(sum1_q));
        s2 = vpr_pkg::sat32(64'(sum2_q));
        res2_d.out_first  = s1[31:0];
        res2_d.out_second = s2[31:0];
        res2_d.saturated  = s1[32] | s2[32];
      end
      vpr_pkg::CMD_SCALE: begin
        s1 = vpr_pkg::sat32(sc1);
        s2 = vpr_pkg::sat32(sc2);
        res2_d.out_first  = s1[31:0];
        res2_d.out_second = s2[31:0];
        res2_d.saturated  = s1[32] | s2[32];
      end
      default: begin
        res2_d.bad_command = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    cmd2_q <= cmd1_q;
    a1_2_q <= a1_1_q;
    a2_2_q <= a2_1_q;
    r2_q   <= r2_d;
    x2_q   <= vpr_pkg::gain_done(gp1_q);
    res2_q <= res2_d;
  end

  // build the queue entry: fold the angle or set up vectoring
  always_comb begin
    logic signed [R_W:0]  zf;
    logic signed [XW-1:0] ax, ay;
    zf = signed'({1'b0, r2_q});
    ax = XW'(a1_2_q) <<< vpr_pkg::GUARD_BITS;
    ay = XW'(a2_2_q) <<< vpr_pkg::GUARD_BITS;
    entry_o     = '0;
    entry_o.op  = vpr_pkg::OP_PASS;
    entry_o.res = res2_q;
    case (cmd2_q)
      vpr_pkg::CMD_P2R: begin
        if (zf > (R_W+1)'(vpr_pkg::HALF_Q16)) begin
          zf = zf - (R_W+1)'(vpr_pkg::MOD_Q16);
        end
        if (zf > (R_W+1)'(vpr_pkg::QUARTER_Q16)) begin
          zf          = zf - (R_W+1)'(vpr_pkg::HALF_Q16);
          entry_o.neg = 1'b1;
        end else if (zf < -(R_W+1)'(vpr_pkg::QUARTER_Q16)) begin
          zf          = zf + (R_W+1)'(vpr_pkg::HALF_Q16);
          entry_o.neg = 1'b1;
        end
        entry_o.op = vpr_pkg::OP_ROT;
        entry_o.x  = x2_q;
        entry_o.y  = '0;
        entry_o.z  = ZW'(zf) <<< vpr_pkg::ANG_SHIFT;
      end
      vpr_pkg::CMD_R2P: begin
        // zero vector stays a pass-through with zero result
        if (a1_2_q != 32'sd0 || a2_2_q != 32'sd0) begin
          entry_o.op = vpr_pkg::OP_VEC;
          if (ax[XW-1]) begin
            entry_o.z = ay[XW-1] ? -ZW'(vpr_pkg::HALF_Q24) : ZW'(vpr_pkg::HALF_Q24);
            entry_o.x = -ax;
            entry_o.y = -ay;
          end else begin
            entry_o.x = ax;
            entry_o.y = ay;
          end
        end
      end
      default: begin
        entry_o.op = vpr_pkg::OP_PASS;
      end
    endcase
  end

  assign push_o = v2_q;

endmodule

// ===== hdl/vpr_queue.sv =====
// Short queue between front end and CORDIC back end, registered read port.
// Uses vpr_pkg for the entry type.
module vpr_queue #(
  parameter int DEPTH = vpr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  vpr_pkg::entry_t data_i,
  output logic            valid_o,
  output vpr_pkg::entry_t data_o,
  output logic            full_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  vpr_pkg::entry_t mem [DEPTH];
  logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   count_q;
  logic            pop;

  assign pop = (count_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      valid_o  <= 1'b0;
    end else begin
      valid_o <= pop;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + CW'(push_i) - CW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= data_i;
    end
    data_o <= mem[rd_ptr_q];
  end

  // hold off new commands while items already in flight could overfill
  assign full_o = (count_q >= CW'(DEPTH - vpr_pkg::FRONT_STAGES));

endmodule

// ===== hdl/vpr_back.sv =====
// Back end: unrolled CORDIC pipeline, sign fix, gain and output rounding.
// Uses vpr_pkg.
module vpr_back #(
  parameter int CORDIC_STEPS = vpr_pkg::CORDIC_STEPS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  vpr_pkg::entry_t entry_i,
  output logic            res_valid_o,
  output vpr_pkg::rsp_t   res_o
);

  localparam int XW = vpr_pkg::XW;
  localparam int ZW = vpr_pkg::ZW;

  vpr_pkg::entry_t       stg_q [1:CORDIC_STEPS];
  vpr_pkg::entry_t       stg_d [1:CORDIC_STEPS];
  logic [CORDIC_STEPS:1] vld_q;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_stage
    localparam logic signed [ZW-1:0] ATAN = ZW'(vpr_pkg::atan_q24(k));
    vpr_pkg::entry_t      cur, nxt;
    logic                 dir;
    logic signed [XW-1:0] xs, ys;
    if (k == 0) begin : g_in
      assign cur = entry_i;
    end else begin : g_reg
      assign cur = stg_q[k];
    end
    always_comb begin
      xs  = cur.x >>> k;
      ys  = cur.y >>> k;
      dir = (cur.op == vpr_pkg::OP_ROT) ? ~cur.z[ZW-1] : cur.y[XW-1];
      nxt = cur;
      if (dir) begin
        nxt.x = cur.x - ys;
        nxt.y = cur.y + xs;
        nxt.z = cur.z - ATAN;
      end else begin
        nxt.x = cur.x + ys;
        nxt.y = cur.y - xs;
        nxt.z = cur.z + ATAN;
      end
    end
    assign stg_d[k+1] = nxt;
  end

  // post stage 1: rotation output or first gain half and angle
  vpr_pkg::entry_t     last;
  logic                p1_v_q;
  vpr_pkg::op_e        p1_op_q;
  vpr_pkg::rsp_t       p1_res_q, p1_res_d;
  vpr_pkg::gain_prod_t p1_gp_q;
  vpr_pkg::rsp_t       res_d;

  assign last = stg_q[CORDIC_STEPS];

  always_comb begin
    logic signed [XW-1:0] rx, ry, sx, sy;
    logic signed [ZW-1:0] az;
    logic [32:0]          s1, s2;
    rx = last.neg ? -last.x : last.x;
    ry = last.neg ? -last.y : last.y;
    sx = (rx + vpr_pkg::GUARD_RND) >>> vpr_pkg::GUARD_BITS;
    sy = (ry + vpr_pkg::GUARD_RND) >>> vpr_pkg::GUARD_BITS;
    az = (last.z + vpr_pkg::ANG_RND) >>> vpr_pkg::ANG_SHIFT;
    s1 = vpr_pkg::sat32(64'(sx));
    s2 = vpr_pkg::sat32(64'(sy));
    p1_res_d = last.res;
    case (last.op)
      vpr_pkg::OP_ROT: begin
        p1_res_d.out_first  = s1[31:0];
        p1_res_d.out_second = s2[31:0];
        p1_res_d.saturated  = s1[32] | s2[32];
      end
      vpr_pkg::OP_VEC: begin
        // clamp overshoot past a half turn, not counted as clipping
        if (az > ZW'(vpr_pkg::HALF_Q16)) begin
          az = ZW'(vpr_pkg::HALF_Q16);
        end else if (az < -ZW'(vpr_pkg::HALF_Q16)) begin
          az = -ZW'(vpr_pkg::HALF_Q16);
        end
        p1_res_d.out_second = az[31:0];
      end
      default: begin
        p1_res_d = last.res;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      p1_v_q      <= 1'b0;
      res_valid_o <= 1'b0;
    end else begin
      vld_q       <= {vld_q[CORDIC_STEPS-1:1], valid_i};
      p1_v_q      <= vld_q[CORDIC_STEPS];
      res_valid_o <= p1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 1; k <= CORDIC_STEPS; k++) begin
      stg_q[k] <= stg_d[k];
    end
    p1_op_q  <= last.op;
    p1_res_q <= p1_res_d;
    p1_gp_q  <= vpr_pkg::gain_prep(last.x);
  end

  // post stage 2: finish magnitude gain, round, clip
  always_comb begin
    logic signed [XW-1:0] mag, sm;
    logic [32:0]          s1;
    mag = vpr_pkg::gain_done(p1_gp_q);
    sm  = (mag + vpr_pkg::GUARD_RND) >>> vpr_pkg::GUARD_BITS;
    s1  = vpr_pkg::sat32(64'(sm));
    res_d = p1_res_q;
    if (p1_op_q == vpr_pkg::OP_VEC) begin
      res_d.out_first = s1[31:0];
      res_d.saturated = s1[32];
    end
  end

  always_ff @(posedge clk_i) begin
    res_o <= res_d;
  end

endmodule

// ===== hdl/vector_polar_rect_unit.sv =====
// Top level of the vector polar/rect unit: front end, queue, CORDIC back end.
// Throughput one item per cycle while busy is low.
// The CORDIC pipeline has one stage per step; the queue drains one entry a cycle.
// The receiver cannot stall; busy rises only if the queue would overfill.
// Reset (rst_ni low, asynchronous) clears all valid flags and queue pointers.
module vector_polar_rect_unit #(
  parameter int CORDIC_STEPS = vpr_pkg::CORDIC_STEPS_DEF,
  parameter int QUEUE_DEPTH  = vpr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  vpr_pkg::req_t req_i,
  output logic          res_valid_o,
  output vpr_pkg::rsp_t res_o
);

  localparam int LAT = CORDIC_STEPS + 6;

  logic            acc;
  logic            push;
  vpr_pkg::entry_t push_entry;
  logic            q_valid;
  vpr_pkg::entry_t q_entry;

  // a beat is taken when start is high and the queue has room
  assign acc = start & ~busy;

  // front: arithmetic commands finish here, conversions get set up
  vpr_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (acc),
    .req_i    (req_i),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  // decouple front and back
  vpr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .valid_o (q_valid),
    .data_o  (q_entry),
    .full_o  (busy)
  );

  // back: CORDIC iterations and output formatting
  vpr_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .entry_i     (q_entry),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // every accepted beat leaves after the fixed latency
  a_lat_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> ##LAT res_valid_o)
    else $error("result missing after accepted beat");

  // no result without an accepted beat
  a_lat_bwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(acc, LAT))
    else $error("result without accepted beat");

  // an invalid command yields zeros and no clip flag
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.bad_command) |->
      (res_o.out_first == 32'sd0 && res_o.out_second == 32'sd0 && !res_o.saturated))
    else $error("invalid command with nonzero result");

  // the back end drains every cycle, so the queue never backs up
  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("queue backed up");

endmodule

// ===== bench/tb_vector_polar_rect_unit.sv =====
// Self-checking bench for vector_polar_rect_unit: directed corners, then random beats
// under several sender idle rates, each result checked against an in-bench predictor.
// Depends on vpr_pkg (payload structs, command codes) and the RTL of the unit.
module tb_vector_polar_rect_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // codes past the last legal command
  localparam logic [2:0] CMD_BAD_LO = 3'd6;
  localparam logic [2:0] CMD_BAD_HI = 3'd7;
  localparam int LATENCY   = 22;
  localparam int LIMIT     = 300000;
  localparam int RND_ITEMS = 1330;

  // arctangent of 2^-k in degrees Q.24 for the first twelve micro-rotations
  localparam longint ATAN_DEG[12] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367
  };
  localparam longint DEG_PER_RAD_Q24 = 961263669;
  localparam longint GAIN = 652032874;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  vpr_pkg::req_t req_i = '0;
  logic res_valid_o;
  vpr_pkg::rsp_t res_o;

  vpr_pkg::rsp_t pending_results[$];
  int   errors = 0;
  int   beats_sent = 0;
  int   results_seen = 0;
  int   cycles = 0;
  int   idle_pct = 0;

  vector_polar_rect_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog: a hung pipeline or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic longint atan_deg(int k);
    if (k < 12) return ATAN_DEG[k];
    return (DEG_PER_RAD_Q24 + (longint'(1) << (k - 1))) >> k;
  endfunction

  // round half up, then arithmetic shift
  function automatic longint rnd_shift(longint v, int s);
    if (s == 0) return v;
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  // multiply by the limiting CORDIC gain, rounded, symmetric in sign
  function automatic longint gain_scale(longint v);
    longint unsigned m, hi, lo, t;
    m  = (v < 0) ? longint'(-v) : v;
    hi = m >> 15;
    lo = m & 64'h7FFF;
    t  = hi * GAIN + ((lo * GAIN) >> 15);
    t  = (t + 64'h4000) >> 15;
    return (v < 0) ? -longint'(t) : longint'(t);
  endfunction

  function automatic logic [31:0] clip32(longint v, inout bit clipped);
    if (v > 64'sd2147483647) begin
      clipped = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      clipped = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic vpr_pkg::rsp_t convert_vector(vpr_pkg::req_t q);
    longint a1, a2, bx, by, f, r1, r2, x, y, z, t;
    longint full_turn, half_turn, quarter_turn, lim;
    bit     flip, clipped;
    vpr_pkg::rsp_t o;
    a1 = q.a_first;
    a2 = q.a_second;
    bx = q.b_x;
    by = q.b_y;
    f  = q.factor;
    r1 = 0;
    r2 = 0;
    flip = 1'b0;
    clipped = 1'b0;
    full_turn    = longint'(360) << 24;
    half_turn    = longint'(180) << 24;
    quarter_turn = longint'(90) << 24;
    o = '0;
    case (q.cmd)
      vpr_pkg::CMD_P2R: begin
        // fold the angle into +-90 degrees, remember whether to mirror
        z = (a2 * 256) % full_turn;
        if (z < 0) z += full_turn;
        if (z > half_turn) z -= full_turn;
        if (z > quarter_turn) begin
          z -= half_turn;
          flip = 1'b1;
        end else if (z < -quarter_turn) begin
          z += half_turn;
          flip = 1'b1;
        end
        x = gain_scale(a1 * 256);
        y = 0;
        for (int k = 0; k < 16; k++) begin
          if (z >= 0) begin
            t = x - (y >>> k); y = y + (x >>> k); z -= atan_deg(k);
          end else begin
            t = x + (y >>> k); y = y - (x >>> k); z += atan_deg(k);
          end
          x = t;
        end
        if (flip) begin
          x = -x;
          y = -y;
        end
        r1 = rnd_shift(x, 8);
        r2 = rnd_shift(y, 8);
      end
      vpr_pkg::CMD_R2P: begin
        if (a1 != 0 || a2 != 0) begin
          x = a1 * 256;
          y = a2 * 256;
          z = 0;
          lim = longint'(180) << 16;
          if (x < 0) begin
            z = (y >= 0) ? half_turn : -half_turn;
            x = -x;
            y = -y;
          end
          for (int k = 0; k < 16; k++) begin
            if (y < 0) begin
              t = x - (y >>> k); y = y + (x >>> k); z -= atan_deg(k);
            end else begin
              t = x + (y >>> k); y = y - (x >>> k); z += atan_deg(k);
            end
            x = t;
          end
          r1 = rnd_shift(gain_scale(x), 8);
          r2 = rnd_shift(z, 8);
          // angle overshoot is clamped silently
          if (r2 > lim) r2 = lim;
          if (r2 < -lim) r2 = -lim;
        end
      end
      vpr_pkg::CMD_ADD: begin
        r1 = a1 + bx;
        r2 = a2 + by;
      end
      vpr_pkg::CMD_SUB: begin
        r1 = a1 - bx;
        r2 = a2 - by;
      end
      vpr_pkg::CMD_NEG: begin
        r1 = -a1;
        r2 = -a2;
      end
      vpr_pkg::CMD_SCALE: begin
        r1 = rnd_shift(a1 * f, 16);
        r2 = rnd_shift(a2 * f, 16);
      end
      default: o.bad_command = 1'b1;
    endcase
    o.out_first  = clip32(r1, clipped);
    o.out_second = clip32(r2, clipped);
    o.saturated  = clipped;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one beat per call, random idle cycles ahead of it
  // ---------------------------------------------------------------------------

  task automatic send_beat(vpr_pkg::req_t r);
    // idle cycle by cycle, so idle_pct is the share of idle cycles
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    // hold the beat until an edge sees busy low
    do @(posedge clk_i); while (busy);
    pending_results.push_back(convert_vector(r));
    beats_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  function automatic vpr_pkg::req_t make_req(logic [2:0] c, longint p, longint q,
                                             longint u = 0, longint v = 0,
                                             longint w = 0);
    vpr_pkg::req_t r;
    r.cmd = c;
    r.a_first = p[31:0];
    r.a_second = q[31:0];
    r.b_x = u[31:0];
    r.b_y = v[31:0];
    r.factor = w[31:0];
    return r;
  endfunction

  // Mix of full-range words, small values and extremes.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0, 1: return $urandom;
      2: return 32'($signed($urandom_range(0, 400000)) - 200000);
      3: return 32'($signed($urandom_range(0, 60)) - 30) <<< 16;
      4: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 20000000)) - 10000000);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: the receiver never stalls, so every strobe is a beat
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    vpr_pkg::rsp_t want;
    if (rst_ni && res_valid_o) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing outstanding: %h", res_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (res_o.out_first !== want.out_first) begin
          $error("out_first expected %0d got %0d", want.out_first, res_o.out_first);
          errors++;
        end
        if (res_o.out_second !== want.out_second) begin
          $error("out_second expected %0d got %0d", want.out_second, res_o.out_second);
          errors++;
        end
        if (res_o.bad_command !== want.bad_command) begin
          $error("bad_command expected %0b got %0b", want.bad_command, res_o.bad_command);
          errors++;
        end
        if (res_o.saturated !== want.saturated) begin
          $error("saturated expected %0b got %0b", want.saturated, res_o.saturated);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Corners: field extremes, every command, folding, zero vector, clamps, clipping.
  task automatic test_corners();
    longint one;
    one = longint'(1) << 16;
    idle_pct = 0;
    send_beat(make_req(vpr_pkg::CMD_P2R, 10 * one, 30 * one));
    send_beat(make_req(vpr_pkg::CMD_P2R, 10 * one, 135 * one));      // fold past +90
    send_beat(make_req(vpr_pkg::CMD_P2R, 10 * one, -135 * one));     // fold past -90
    send_beat(make_req(vpr_pkg::CMD_P2R, 5 * one, 32'sh7FFF_FFFF));  // large angle
    send_beat(make_req(vpr_pkg::CMD_P2R, 32'sh7FFF_FFFF, 45 * one)); // largest magnitude
    send_beat(make_req(vpr_pkg::CMD_P2R, -32'sh8000_0000, 180 * one));
    send_beat(make_req(vpr_pkg::CMD_R2P, 0, 0));                     // zero vector
    send_beat(make_req(vpr_pkg::CMD_R2P, -3 * one, 0));              // negative x, y zero
    send_beat(make_req(vpr_pkg::CMD_R2P, -3 * one, -1));             // negative x, y below
    send_beat(make_req(vpr_pkg::CMD_R2P, -one, 1));
    send_beat(make_req(vpr_pkg::CMD_R2P, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    send_beat(make_req(vpr_pkg::CMD_R2P, -32'sh8000_0000, -32'sh8000_0000));
    send_beat(make_req(vpr_pkg::CMD_ADD, 32'sh7FFF_FFFF, 1, 1, 2));
    send_beat(make_req(vpr_pkg::CMD_ADD, -32'sh8000_0000, 0, -1, 0));
    send_beat(make_req(vpr_pkg::CMD_SUB, -32'sh8000_0000, 32'sh7FFF_FFFF, 1, -1));
    send_beat(make_req(vpr_pkg::CMD_SUB, 5, 7, 3, 9));
    send_beat(make_req(vpr_pkg::CMD_NEG, -32'sh8000_0000, 12345));
    send_beat(make_req(vpr_pkg::CMD_NEG, 32'sh7FFF_FFFF, -1));
    send_beat(make_req(vpr_pkg::CMD_SCALE, 3 * one, -2 * one, 0, 0, one + 32768));
    send_beat(make_req(vpr_pkg::CMD_SCALE, 32'sh7FFF_FFFF, -32'sh8000_0000,
                       0, 0, 32'sh7FFF_FFFF));
    send_beat(make_req(vpr_pkg::CMD_SCALE, 1, -1, 0, 0, 32768));     // round half up
    send_beat(make_req(CMD_BAD_LO, 32'hFFFF_FFFF, 1, 2, 3, 4));
    send_beat(make_req(CMD_BAD_HI, 7, 8, 9, 10, 11));
  endtask

  // Random beats at the given sender idle rate.
  task automatic test_random(int pct, int count);
    vpr_pkg::req_t r;
    idle_pct = pct;
    for (int n = 0; n < count; n++) begin
      r.cmd      = 3'($urandom_range(7));
      r.a_first  = rand_word();
      r.a_second = rand_word();
      r.b_x      = rand_word();
      r.b_y      = rand_word();
      r.factor   = rand_word();
      send_beat(r);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corners();
    drain_results();                       // pause until every result is back
    test_random(0, RND_ITEMS / 4);
    test_random(46, RND_ITEMS / 4);
    drain_results();
    test_random(35, RND_ITEMS / 4);
    test_random(0, RND_ITEMS - 3 * (RND_ITEMS / 4));
    drain_results();

    $display("covered %0d beats over all commands, %0d results checked,",
             beats_sent, results_seen);
    $display("with sender idle rates of 0, 35 and 46 percent");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
